// ===== rtl/core/ucd_pkg.sv =====
// shared types and constants for the undirected cycle detector
// no dependencies; imported by the controller and the top level
`default_nettype none

package ucd_pkg;

  localparam int END_W = 7;
  localparam int CFG_W = 8;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 8'd128;

  localparam logic CMD_ADD_EDGE = 1'b0;
  localparam logic CMD_CLEAR    = 1'b1;

  typedef struct packed {
    logic cycle_found;
    logic edge_ignored;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ucd_root_ram.sv =====
// root table storage: one write port, one read port, registered read data
// a read that hits the entry written in the same cycle returns the new value
// no dependencies
`default_nettype none

module ucd_root_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] q_r;
  logic [DW-1:0] fwd_data_r;
  logic          fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
    fwd_data_r <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= rd_en && wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

`default_nettype wire

// ===== rtl/core/ucd_ctrl.sv =====
// sequencer: root walks with path halving, union, clearing sweep
// depends on ucd_pkg; drives the ports of ucd_root_ram
`default_nettype none

module ucd_ctrl #(
  parameter int MAX_VERTICES = 128,
  parameter int AW           = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_command,
  input  wire logic [ucd_pkg::END_W-1:0] in_end_a,
  input  wire logic [ucd_pkg::END_W-1:0] in_end_b,
  input  wire logic                      in_out_of_range,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output ucd_pkg::res_t                  res,
  output logic                           wr_en,
  output logic      [AW-1:0]             wr_addr,
  output logic      [AW-1:0]             wr_data,
  output logic                           rd_en,
  output logic      [AW-1:0]             rd_addr,
  input  wire logic [AW-1:0]             rd_data
);

  import ucd_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_VERTICES - 1);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_UNION = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic          side_r, side_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic [AW-1:0] up_r, up_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic [AW-1:0] rb_r, rb_nxt;
  logic [AW-1:0] eb_r, eb_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          drop_r, drop_nxt;
  logic          flag_r, flag_nxt;
  logic          find_done;
  logic [AW-1:0] root;

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    x_nxt     = x_r;
    up_nxt    = up_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    eb_nxt    = eb_r;
    cnt_nxt   = cnt_r;
    drop_nxt  = drop_r;
    flag_nxt  = flag_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = x_r;
    wr_data   = rd_data;
    rd_en     = 1'b0;
    rd_addr   = rd_data;
    find_done = 1'b0;
    root      = x_r;

    case (state_r)
      S_INIT, S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r;
        wr_data = cnt_r;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_IDX) begin
          flag_nxt  = 1'b0;
          drop_nxt  = 1'b0;
          state_nxt = (state_r == S_CLEAR) ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt    = AW'(in_end_a);
          eb_nxt   = AW'(in_end_b);
          side_nxt = 1'b0;
          if (in_command == CMD_CLEAR) begin
            cnt_nxt   = '0;
            state_nxt = S_CLEAR;
          end else if (in_out_of_range) begin
            drop_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            drop_nxt  = 1'b0;
            rd_en     = 1'b1;
            rd_addr   = AW'(in_end_a);
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        // rd_data is the parent of x
        if (rd_data == x_r) begin
          find_done = 1'b1;
          root      = x_r;
        end else begin
          up_nxt    = rd_data;
          rd_en     = 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        // rd_data is the grandparent of x: halve the path, then move up one
        wr_en   = 1'b1;
        wr_addr = x_r;
        wr_data = rd_data;
        x_nxt   = up_r;
        up_nxt  = rd_data;
        if (rd_data == up_r) begin
          find_done = 1'b1;
          root      = up_r;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_UNION: begin
        if (ra_r == rb_r) begin
          flag_nxt = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = (ra_r < rb_r) ? rb_r : ra_r;
          wr_data = (ra_r < rb_r) ? ra_r : rb_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
        cnt_nxt   = '0;
      end
    endcase

    if (find_done) begin
      if (!side_r) begin
        // second walk starts at once; a same-entry write is forwarded by the ram
        ra_nxt    = root;
        side_nxt  = 1'b1;
        x_nxt     = eb_r;
        rd_en     = 1'b1;
        rd_addr   = eb_r;
        state_nxt = S_CHK;
      end else begin
        rb_nxt    = root;
        state_nxt = S_UNION;
      end
    end
  end

  assign res.cycle_found  = flag_r;
  assign res.edge_ignored = drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
      flag_r  <= 1'b0;
      drop_r  <= 1'b0;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flag_r  <= flag_nxt;
      drop_r  <= drop_nxt;
      side_r  <= side_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    up_r <= up_nxt;
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    eb_r <= eb_nxt;
  end

  // the forest is acyclic, so a grandparent is never the vertex itself
  a_no_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (rd_data != x_r))
    else $error("root table holds a two-entry loop");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(flag_r) |-> ($past(state_r) == S_CLEAR))
    else $error("cycle flag dropped outside a clear");

  a_quiet_table: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) || (state_r == S_DONE)) |-> !wr_en)
    else $error("root table written while no edge is in progress");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((wr_addr <= LAST_IDX) && (wr_data <= LAST_IDX)))
    else $error("root table access beyond the vertex range");

endmodule

`default_nettype wire

// ===== rtl/core/undirected_cycle_detector_top.sv =====
// Undirected cycle detector. Each transfer on the input channel either adds an
// edge or clears the graph, and yields one result: whether the graph so far
// holds a cycle, and whether the edge was dropped because an end was at or
// above the vertex count (self-loops and repeated edges count as cycles). An
// added edge walks from each end to its root; each path-halving step on the
// two root walks is one read of the single-read-port root table. A clear
// sweeps the root table one entry a cycle. After reset the same sweep runs
// with in_ready low; configuration writes are taken throughout. A finished
// result waits in the output register while the next item is transferred in.
// depends on ucd_pkg, ucd_root_ram and ucd_ctrl
`default_nettype none

module undirected_cycle_detector_top #(
  parameter int MAX_VERTICES = 128
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [ucd_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_command,
  input  wire logic [ucd_pkg::END_W-1:0] in_end_a,
  input  wire logic [ucd_pkg::END_W-1:0] in_end_b,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_cycle_found,
  output logic                           out_edge_ignored
);

  import ucd_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int LW = ($clog2(MAX_VERTICES + 1) > CFG_W) ? $clog2(MAX_VERTICES + 1) : CFG_W;

  logic [CFG_W-1:0] vertex_count_r;
  logic [LW-1:0]    limit;
  logic             out_of_range;

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // counts above the table size act as the table size
  assign limit = (LW'(vertex_count_r) > LW'(MAX_VERTICES)) ? LW'(MAX_VERTICES)
                                                          : LW'(vertex_count_r);
  assign out_of_range = (LW'(in_end_a) >= limit) || (LW'(in_end_b) >= limit);

  ucd_root_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ucd_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_end_a        (in_end_a),
    .in_end_b        (in_end_b),
    .in_out_of_range (out_of_range),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

  // output register: loads when empty or when its transfer completes
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cycle_found  = out_res_r.cycle_found;
  assign out_edge_ignored = out_res_r.edge_ignored;

endmodule

`default_nettype wire
